FILE: hw/rtl/spms_pkg.sv
// Package for the shared-pool multi-stack block.
// Holds opcode, status and FSM types, the controller command struct and fixed widths.
// No dependencies.
package spms_pkg;

  localparam int OPCODE_W = 2;
  localparam int SID_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0]  STACK_COUNT_RST = 4'd8;
  localparam logic [DATA_W-1:0] ERR_DATA        = 32'hFFFF_FFFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_INVALID   = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the item and launch the slot memory read
    logic execute;    // apply the update and load the result registers
    logic cfg_write;  // write the stack count register
  } ctrl_cmd_t;

endpackage

FILE: hw/rtl/spms_ctrl.sv
// Controller for the shared-pool multi-stack block.
// Two-state sequencer issuing capture/execute commands; uses spms_pkg.
module spms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                cfg_valid,
  output logic                busy,
  output logic                cfg_ready,
  output logic                out_valid,
  output spms_pkg::ctrl_cmd_t cmd
);

  spms_pkg::state_t state_r;
  spms_pkg::state_t state_nxt;
  logic             out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spms_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = spms_pkg::ST_EXEC;
        end
      end
      spms_pkg::ST_EXEC: begin
        state_nxt = spms_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = spms_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and commands
  always_comb begin
    busy          = 1'b0;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    case (state_r)
      spms_pkg::ST_IDLE: begin
        cmd.capture = start;
      end
      spms_pkg::ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
    cfg_ready     = !busy;
    cmd.cfg_write = cfg_valid && !busy;
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spms_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.execute;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == spms_pkg::ST_EXEC))
    else $error("capture not followed by execute");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> (out_valid && !cmd.execute))
    else $error("result strobe missing after execute");
`endif

endmodule

FILE: hw/rtl/spms_dp.sv
// Datapath for the shared-pool multi-stack block.
// Head registers, free list, slot value/link memories, result registers; uses spms_pkg.
module spms_dp #(
  parameter int TOTAL_SLOTS = 64,
  parameter int MAX_STACKS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  spms_pkg::ctrl_cmd_t                   cmd,
  input  logic [spms_pkg::OPCODE_W-1:0]         in_opcode,
  input  logic [spms_pkg::SID_W-1:0]            in_stack_id,
  input  logic signed [spms_pkg::DATA_W-1:0]    in_push_value,
  input  logic [spms_pkg::CFG_W-1:0]            cfg_data,
  output logic signed [spms_pkg::DATA_W-1:0]    out_read_data,
  output logic [spms_pkg::STATUS_W-1:0]         out_status,
  output logic                                  out_stack_empty,
  output logic                                  out_pool_full
);

  localparam int AW = $clog2(TOTAL_SLOTS);
  localparam int LW = $clog2(TOTAL_SLOTS + 1);
  localparam int HW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(TOTAL_SLOTS);

  // Stack count register
  logic [spms_pkg::CFG_W-1:0] stack_count_r;

  // Pool state
  logic [LW-1:0]              heads_r [MAX_STACKS];
  logic [LW-1:0]              free_head_r;
  logic [LW-1:0]              free_head_nxt;
  logic [LW-1:0]              wm_r;        // slots below this have been allocated once
  logic [LW-1:0]              wm_nxt;
  logic [spms_pkg::DATA_W-1:0] mem_value_r [TOTAL_SLOTS];
  logic [LW-1:0]              mem_link_r  [TOTAL_SLOTS];

  // Captured item
  logic [spms_pkg::OPCODE_W-1:0] op_r;
  logic [spms_pkg::SID_W-1:0]    sid_r;
  logic [spms_pkg::DATA_W-1:0]   val_r;
  logic [LW-1:0]                 top_r;
  logic [LW-1:0]                 addr_r;
  logic [spms_pkg::DATA_W-1:0]   rd_value_r;
  logic [LW-1:0]                 rd_link_r;

  // Result registers
  logic [spms_pkg::DATA_W-1:0]   res_data_r;
  logic [spms_pkg::STATUS_W-1:0] res_status_r;
  logic                          res_empty_r;
  logic                          res_full_r;

  logic                          in_sid_ok;
  logic [LW-1:0]                 top_sel;
  logic [LW-1:0]                 rd_sel;
  logic [HW-1:0]                 head_idx;
  logic                          sid_ok;
  logic [LW-1:0]                 link_eff;
  logic                          head_we;
  logic [LW-1:0]                 head_wdata;
  logic                          val_we;
  logic                          link_we;
  logic [LW-1:0]                 link_wdata;
  logic [spms_pkg::DATA_W-1:0]   res_data;
  spms_pkg::status_t             res_status;
  logic                          res_empty;
  logic                          res_full;

  // Pick the slot to read at accept time
  always_comb begin
    in_sid_ok = int'(in_stack_id) < MAX_STACKS;
    top_sel   = in_sid_ok ? heads_r[HW'(in_stack_id)] : NULL_LINK;
    rd_sel    = (in_opcode == spms_pkg::OP_PUSH) ? free_head_r : top_sel;
  end

  // Capture the item and read the slot memories
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_opcode;
      sid_r      <= in_stack_id;
      val_r      <= in_push_value;
      top_r      <= top_sel;
      addr_r     <= rd_sel;
      rd_value_r <= mem_value_r[rd_sel[AW-1:0]];
      rd_link_r  <= mem_link_r[rd_sel[AW-1:0]];
    end
  end

  // Decide the update and the result
  always_comb begin
    head_idx      = HW'(sid_r);
    sid_ok        = ({1'b0, sid_r} < stack_count_r) && (int'(sid_r) < MAX_STACKS);
    // a never-allocated slot still links to its successor
    link_eff      = (addr_r >= wm_r) ? (addr_r + LW'(1)) : rd_link_r;
    free_head_nxt = free_head_r;
    wm_nxt        = wm_r;
    head_we       = 1'b0;
    head_wdata    = link_eff;
    val_we        = 1'b0;
    link_we       = 1'b0;
    link_wdata    = top_r;
    res_data      = spms_pkg::ERR_DATA;
    res_status    = spms_pkg::STAT_OK;
    res_empty     = 1'b1;
    res_full      = (free_head_r == NULL_LINK);
    if (!sid_ok) begin
      res_status = spms_pkg::STAT_INVALID;
    end else begin
      case (op_r)
        spms_pkg::OP_PUSH: begin
          if (free_head_r == NULL_LINK) begin
            res_status = spms_pkg::STAT_OVERFLOW;
            res_empty  = (top_r == NULL_LINK);
            res_full   = 1'b1;
          end else begin
            free_head_nxt = link_eff;
            val_we        = 1'b1;
            link_we       = 1'b1;
            link_wdata    = top_r;
            head_we       = 1'b1;
            head_wdata    = free_head_r;
            if (free_head_r == wm_r) begin
              wm_nxt = wm_r + LW'(1);
            end
            res_empty = 1'b0;
            res_full  = (link_eff == NULL_LINK);
          end
        end
        spms_pkg::OP_POP: begin
          if (top_r == NULL_LINK) begin
            res_status = spms_pkg::STAT_UNDERFLOW;
          end else begin
            res_data      = rd_value_r;
            head_we       = 1'b1;
            head_wdata    = link_eff;
            link_we       = 1'b1;
            link_wdata    = free_head_r;
            free_head_nxt = top_r;
            res_empty     = (link_eff == NULL_LINK);
            res_full      = 1'b0;
          end
        end
        default: begin
          // peek, and the unused opcode acts the same
          if (top_r == NULL_LINK) begin
            res_status = spms_pkg::STAT_UNDERFLOW;
          end else begin
            res_data  = rd_value_r;
            res_empty = 1'b0;
          end
        end
      endcase
    end
  end

  // Write the slot memories
  always_ff @(posedge clk) begin
    if (cmd.execute && val_we) begin
      mem_value_r[addr_r[AW-1:0]] <= val_r;
    end
    if (cmd.execute && link_we) begin
      mem_link_r[addr_r[AW-1:0]] <= link_wdata;
    end
  end

  // Advance heads, free list, fill count and stack count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STACKS; i++) begin
        heads_r[i] <= NULL_LINK;
      end
      free_head_r   <= '0;
      wm_r          <= '0;
      stack_count_r <= spms_pkg::STACK_COUNT_RST;
    end else begin
      if (cmd.execute) begin
        free_head_r <= free_head_nxt;
        wm_r        <= wm_nxt;
        if (head_we) begin
          heads_r[head_idx] <= head_wdata;
        end
      end
      if (cmd.cfg_write) begin
        stack_count_r <= cfg_data;
      end
    end
  end

  // Load the result registers
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_data_r   <= res_data;
      res_status_r <= res_status;
      res_empty_r  <= res_empty;
      res_full_r   <= res_full;
    end
  end

  assign out_read_data   = res_data_r;
  assign out_status      = res_status_r;
  assign out_stack_empty = res_empty_r;
  assign out_pool_full   = res_full_r;

`ifndef ASSERT_OFF
  a_wm_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> (wm_r == $past(wm_r)) || (wm_r == $past(wm_r) + LW'(1)))
    else $error("fill count moved by more than one");

  a_pop_frees_top: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && sid_ok && (op_r == spms_pkg::OP_POP) && (top_r != NULL_LINK))
    |=> (free_head_r == $past(top_r)))
    else $error("popped slot not returned to free list");

  a_push_sets_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && sid_ok && (op_r == spms_pkg::OP_PUSH) && (free_head_r != NULL_LINK))
    |=> (heads_r[$past(head_idx)] == $past(free_head_r)))
    else $error("push did not move stack head to allocated slot");
`endif

endmodule

FILE: hw/rtl/shared_pool_multi_stack.sv
// Top level of the shared-pool multi-stack block.
// Joins the controller (spms_ctrl) and the datapath (spms_dp); uses spms_pkg.
//
// Each item has an accept cycle and an execute cycle. The accept cycle reads
// the stack head register and launches the slot value/link memory read; the
// execute cycle uses the registered read data to update heads, free list and
// memories. busy is high during the execute cycle, when start is ignored, so
// a new item cannot start before the last has executed. The result is loaded
// in the execute cycle and driven in the cycle after it, marked by out_valid
// for exactly one cycle; the receiver cannot stall it and must take it then.
// No clearing pass follows reset: the link memory is tracked by a fill count,
// so items are taken at once after reset, config writes whenever busy is low.
module shared_pool_multi_stack #(
  parameter int TOTAL_SLOTS = 64,
  parameter int MAX_STACKS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [spms_pkg::OPCODE_W-1:0]         in_opcode,
  input  logic [spms_pkg::SID_W-1:0]            in_stack_id,
  input  logic signed [spms_pkg::DATA_W-1:0]    in_push_value,
  output logic                                  out_valid,
  output logic signed [spms_pkg::DATA_W-1:0]    out_read_data,
  output logic [spms_pkg::STATUS_W-1:0]         out_status,
  output logic                                  out_stack_empty,
  output logic                                  out_pool_full,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [spms_pkg::CFG_W-1:0]            cfg_data
);

  spms_pkg::ctrl_cmd_t cmd;

  // Sequence each item
  spms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Pool storage and update logic
  spms_dp #(
    .TOTAL_SLOTS (TOTAL_SLOTS),
    .MAX_STACKS  (MAX_STACKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_stack_id     (in_stack_id),
    .in_push_value   (in_push_value),
    .cfg_data        (cfg_data),
    .out_read_data   (out_read_data),
    .out_status      (out_status),
    .out_stack_empty (out_stack_empty),
    .out_pool_full   (out_pool_full)
  );

endmodule
